// ----- sv/layer_window_blend_compositor_macros.svh -----
// Assertion macros for the layer window blend compositor.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LAYER_WINDOW_BLEND_COMPOSITOR_MACROS_SVH
`define LAYER_WINDOW_BLEND_COMPOSITOR_MACROS_SVH
`ifndef ASSERT_OFF
`define LWBC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LWBC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define LWBC_ASSERT(label, clk, rst, prop, msg)
`define LWBC_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ----- sv/lwbc_pkg.sv -----
// Shared types, codes and helpers of the layer window blend compositor.
// No dependencies; imported by every module of the block.
`default_nettype none
package lwbc_pkg;

  typedef logic [14:0] rgb_t;
  typedef logic [4:0]  chan_t;

  typedef enum logic [2:0] {
    CFG_DISPLAY  = 3'd0,
    CFG_BLEND    = 3'd1,
    CFG_ALPHA    = 3'd2,
    CFG_BRIGHT   = 3'd3,
    CFG_WIN0     = 3'd4,
    CFG_WIN1     = 3'd5,
    CFG_MASKS    = 3'd6,
    CFG_BACKDROP = 3'd7
  } cfg_reg_t;

  localparam logic [2:0] LAYER_OBJ      = 3'd4;
  localparam logic [2:0] LAYER_BACKDROP = 3'd5;

  localparam chan_t CHAN_MAX   = 5'd31;
  localparam chan_t WEIGHT_MAX = 5'd16;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_ALPHA  = 2'd1,
    OP_BRIGHT = 2'd2,
    OP_DARK   = 2'd3
  } blend_op_t;

  typedef struct packed {
    logic [15:0] display;
    logic [13:0] blend;
    logic [15:0] alpha;
    logic [4:0]  bright;
    logic [31:0] win0;
    logic [31:0] win1;
    logic [31:0] masks;
    rgb_t        backdrop;
  } cfg_t;

  typedef struct packed {
    logic [7:0]      x;
    logic [7:0]      line;
    logic [3:0][14:0] bg_color;
    logic [3:0]      bg_opaque;
    logic [7:0]      bg_priorities;
    rgb_t            obj_color;
    logic            obj_opaque;
    logic [1:0]      obj_priority;
    logic            obj_semi;
  } pixel_t;

  // after window stage: per-layer visibility, bit 4 is the sprite
  typedef struct packed {
    logic [4:0]       vis;
    logic             blend_en;
    logic [3:0][14:0] bg_color;
    logic [7:0]       bg_priorities;
    rgb_t             obj_color;
    logic [1:0]       obj_priority;
    logic             obj_semi;
  } lwin_t;

  // after ranking stage: top and second layer
  typedef struct packed {
    rgb_t       col1;
    rgb_t       col2;
    logic [2:0] lay1;
    logic [2:0] lay2;
    logic       semi;
    logic       blend_en;
  } rank_t;

  function automatic chan_t clamp16(input chan_t v);
    return (v > WEIGHT_MAX) ? WEIGHT_MAX : v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/layer_window_blend_compositor.sv -----
// Top level of the layer window blend compositor: config registers and stage chain.
// Depends on lwbc_pkg, lwbc_window, lwbc_rank, lwbc_blend and the macros header.
//
//  channel   direction  handshake                     payload
//  cfg       in         cfg_valid / cfg_ready         cfg_index, cfg_data
//  s_axis    in         s_axis_tvalid / s_axis_tready s_axis_tdata (one pixel)
//  m_axis    out        m_axis_tvalid / m_axis_tready m_axis_tdata (RGB555)
//
// One pixel per cycle sustained while the output is ready; the path runs through the window,
// ranking, product and scale stages, each ending in a register.
// Reset clears all stage valid bits and every config register.
// Each stage holds while full and its successor cannot accept, so bubbles are
// squeezed out and a stalled output still lets upstream stages fill.
`default_nettype none
`include "layer_window_blend_compositor_macros.svh"
module layer_window_blend_compositor
  import lwbc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pixel_x, pixel_line, bg0_color, bg1_color, bg2_color, bg3_color,
  // bg_opaque, bg_priorities, obj_color, obj_opaque, obj_priority, obj_semi
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pixel_color
  output logic [15:0]       m_axis_tdata
);

  cfg_t   cfg;
  pixel_t pix;
  lwin_t  win_data;
  rank_t  rank_data;
  rgb_t   color;
  logic   win_valid, win_ready;
  logic   rank_valid, rank_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DISPLAY:  cfg.display  <= cfg_data[15:0];
        CFG_BLEND:    cfg.blend    <= cfg_data[13:0];
        CFG_ALPHA:    cfg.alpha    <= cfg_data[15:0];
        CFG_BRIGHT:   cfg.bright   <= cfg_data[4:0];
        CFG_WIN0:     cfg.win0     <= cfg_data;
        CFG_WIN1:     cfg.win1     <= cfg_data;
        CFG_MASKS:    cfg.masks    <= cfg_data;
        CFG_BACKDROP: cfg.backdrop <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pix.x             = s_axis_tdata[7:0];
    pix.line          = s_axis_tdata[15:8];
    pix.bg_color[0]   = s_axis_tdata[30:16];
    pix.bg_color[1]   = s_axis_tdata[45:31];
    pix.bg_color[2]   = s_axis_tdata[60:46];
    pix.bg_color[3]   = s_axis_tdata[75:61];
    pix.bg_opaque     = s_axis_tdata[79:76];
    pix.bg_priorities = s_axis_tdata[87:80];
    pix.obj_color     = s_axis_tdata[102:88];
    pix.obj_opaque    = s_axis_tdata[103];
    pix.obj_priority  = s_axis_tdata[105:104];
    pix.obj_semi      = s_axis_tdata[106];
  end

  lwbc_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_pix    (pix),
    .out_valid (win_valid),
    .out_ready (win_ready),
    .out_data  (win_data)
  );

  lwbc_rank u_rank (
    .clk       (clk),
    .rst       (rst),
    .backdrop  (cfg.backdrop),
    .in_valid  (win_valid),
    .in_ready  (win_ready),
    .in_data   (win_data),
    .out_valid (rank_valid),
    .out_ready (rank_ready),
    .out_data  (rank_data)
  );

  lwbc_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (rank_valid),
    .in_ready  (rank_ready),
    .in_data   (rank_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_color (color)
  );

  assign m_axis_tdata = {1'b0, color};

  // backpressure can only start at a full, stalled output
  `LWBC_ASSERT(a_stall_origin, clk, rst, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "input stalled without a stalled output")
  `LWBC_ASSERT_NEXT(a_accept_fills_window, clk, rst, s_axis_tvalid && s_axis_tready, win_valid, "accepted pixel missing from window stage")
  `LWBC_ASSERT(a_reset_empties_output, clk, rst, $past(rst) |-> !m_axis_tvalid, "output valid right after reset")

endmodule
`default_nettype wire

// ----- sv/lwbc_window.sv -----
// Window stage: window flags, video mode masking, layer visibility.
// Depends on lwbc_pkg.
`default_nettype none
module lwbc_window
  import lwbc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire pixel_t in_pix,
  output logic        out_valid,
  input  wire logic   out_ready,
  output lwin_t       out_data
);

  function automatic logic in_span(input logic [7:0] p, input logic [7:0] s,
                                   input logic [7:0] e);
    if (s <= e) return (p >= s) && (p < e);
    return (p >= s) || (p < e);
  endfunction

  function automatic logic in_window(input logic [31:0] b, input logic [7:0] x,
                                     input logic [7:0] y);
    return in_span(y, b[31:24], b[23:16]) && in_span(x, b[15:8], b[7:0]);
  endfunction

  logic [2:0] mode;
  logic [3:0] en_m;
  logic [5:0] flags;
  logic       w0, w1, wo;
  lwin_t      data_next;

  assign mode = cfg.display[2:0];
  assign w0   = cfg.display[13];
  assign w1   = cfg.display[14];
  assign wo   = cfg.display[15];

  always_comb begin
    case (mode) inside
      3'd1:         en_m = cfg.display[11:8] & 4'h7;
      3'd2:         en_m = cfg.display[11:8] & 4'hC;
      [3'd3:3'd5]:  en_m = cfg.display[11:8] & 4'h4;
      default:      en_m = cfg.display[11:8];
    endcase
  end

  always_comb begin
    flags = 6'h3F;
    if (w0 || w1 || wo) begin
      flags = cfg.masks[21:16];
      if (wo && in_pix.obj_opaque) flags = cfg.masks[29:24];
      if (w1 && in_window(cfg.win1, in_pix.x, in_pix.line)) flags = cfg.masks[13:8];
      if (w0 && in_window(cfg.win0, in_pix.x, in_pix.line)) flags = cfg.masks[5:0];
    end
  end

  always_comb begin
    data_next.vis[3:0]     = en_m & flags[3:0] & in_pix.bg_opaque;
    data_next.vis[4]       = cfg.display[12] & in_pix.obj_opaque & flags[4];
    data_next.blend_en     = flags[5];
    data_next.bg_color     = in_pix.bg_color;
    data_next.bg_priorities = in_pix.bg_priorities;
    data_next.obj_color    = in_pix.obj_color;
    data_next.obj_priority = in_pix.obj_priority;
    data_next.obj_semi     = in_pix.obj_semi;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lwbc_rank.sv -----
// Ranking stage: top and second visible layer by priority, backdrop fallback.
// Depends on lwbc_pkg.
`default_nettype none
module lwbc_rank
  import lwbc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire rgb_t  backdrop,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire lwin_t in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output rank_t      out_data
);

  logic [4:0][4:0]  key;
  logic [4:0][14:0] col;
  logic [4:0]       k1, k2;
  rgb_t             c1, c2;
  logic [2:0]       l1, l2;
  rank_t            data_next;

  // backgrounds sort after a sprite of equal priority, lower number first
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      key[i] = {in_data.bg_priorities[2*i +: 2], 3'(i + 1)};
      col[i] = in_data.bg_color[i];
    end
    key[4] = {in_data.obj_priority, 3'b000};
    col[4] = in_data.obj_color;
  end

  always_comb begin
    k1 = 5'h1F;
    k2 = 5'h1F;
    c1 = backdrop;
    c2 = backdrop;
    l1 = LAYER_BACKDROP;
    l2 = LAYER_BACKDROP;
    for (int i = 0; i < 5; i++) begin
      if (in_data.vis[i]) begin
        if (key[i] < k1) begin
          k2 = k1;
          c2 = c1;
          l2 = l1;
          k1 = key[i];
          c1 = col[i];
          l1 = 3'(i);
        end else if (key[i] < k2) begin
          k2 = key[i];
          c2 = col[i];
          l2 = 3'(i);
        end
      end
    end
  end

  always_comb begin
    data_next.col1     = c1;
    data_next.col2     = c2;
    data_next.lay1     = l1;
    data_next.lay2     = l2;
    data_next.semi     = in_data.obj_semi;
    data_next.blend_en = in_data.blend_en;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lwbc_blend.sv -----
// Blend stages: effect select and channel products, then sum, scale, saturate.
// Depends on lwbc_pkg.
`default_nettype none
module lwbc_blend
  import lwbc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire rank_t in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output rgb_t       out_color
);

  logic [5:0] first_mask, second_mask;
  blend_op_t  bmode;
  logic       first, semi_top;
  chan_t      ea, eb, ey, w0;
  blend_op_t  op_next;

  logic [2:0][8:0] p0_next, p1_next;

  // product stage registers
  logic            mul_valid, mul_ready;
  blend_op_t       mul_op;
  rgb_t            mul_col;
  logic [2:0][8:0] mul_p0, mul_p1;

  rgb_t color_next;

  assign first_mask  = cfg.blend[5:0];
  assign second_mask = cfg.blend[13:8];
  assign bmode       = blend_op_t'(cfg.blend[7:6]);
  assign first       = first_mask[in_data.lay1];
  assign semi_top    = (in_data.lay1 == LAYER_OBJ) && in_data.semi;
  assign ea = clamp16(cfg.alpha[4:0]);
  assign eb = clamp16(cfg.alpha[12:8]);
  assign ey = clamp16(cfg.bright);

  always_comb begin
    op_next = OP_NONE;
    if (in_data.blend_en) begin
      if (semi_top || (bmode == OP_ALPHA && first)) begin
        if (second_mask[in_data.lay2]) op_next = OP_ALPHA;
      end else if (bmode == OP_BRIGHT && first) begin
        op_next = OP_BRIGHT;
      end else if (bmode == OP_DARK && first) begin
        op_next = OP_DARK;
      end
    end
  end

  assign w0 = (op_next == OP_ALPHA) ? ea : ey;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [9:0] m0, pa, pb;
      m0 = (op_next == OP_BRIGHT) ? 10'(CHAN_MAX - in_data.col1[5*k +: 5])
                                  : 10'(in_data.col1[5*k +: 5]);
      pa = m0 * 10'(w0);
      pb = 10'(in_data.col2[5*k +: 5]) * 10'(eb);
      p0_next[k] = pa[8:0];
      p1_next[k] = pb[8:0];
    end
  end

  assign mul_ready = !out_valid || out_ready;
  assign in_ready  = !mul_valid || mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (in_ready) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mul_op  <= op_next;
      mul_col <= in_data.col1;
      mul_p0  <= p0_next;
      mul_p1  <= p1_next;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [9:0] sum;
      chan_t      c;
      c   = mul_col[5*k +: 5];
      sum = {1'b0, mul_p0[k]} + {1'b0, mul_p1[k]};
      case (mul_op)
        OP_ALPHA:  color_next[5*k +: 5] = (sum[9:4] > 6'(CHAN_MAX)) ? CHAN_MAX : sum[8:4];
        OP_BRIGHT: color_next[5*k +: 5] = c + mul_p0[k][8:4];
        OP_DARK:   color_next[5*k +: 5] = c - mul_p0[k][8:4];
        default:   color_next[5*k +: 5] = c;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mul_ready) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid && mul_ready) begin
      out_color <= color_next;
    end
  end

endmodule
`default_nettype wire

// ----- bench/layer_window_blend_compositor_tb.sv -----
// Self-checking bench for layer_window_blend_compositor: directed vectors, then random phases.
// Each output is compared with a listed colour or the internal model; depends on lwbc_pkg only.
module layer_window_blend_compositor_tb;
  import lwbc_pkg::*;

  localparam logic [2:0] MODE_NO_BG3  = 3'd1;
  localparam logic [2:0] MODE_NO_BG01 = 3'd2;
  localparam logic [2:0] MODE_BG2_LO  = 3'd3;
  localparam logic [2:0] MODE_BG2_HI  = 3'd5;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    int     setup;
    pixel_t pix;
    bit     known;
    rgb_t   color;
  } vec_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // pixel_x, pixel_line, bg0..bg3 color, bg_opaque, bg_priorities,
  // obj_color, obj_opaque, obj_priority, obj_semi, zero fill
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // pixel_color, zero fill
  logic [15:0]  m_axis_tdata;

  cfg_t  regs_now;
  rgb_t  colors_due[$];
  vec_t  directed[$];
  cfg_t  setups[8];
  bit    steady;
  int    errors;
  int    idle_cycles;

  layer_window_blend_compositor u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit in_span(input logic [7:0] p, input logic [7:0] lo,
                                 input logic [7:0] hi);
    if (lo <= hi) return (p >= lo) && (p < hi);
    return (p >= lo) || (p < hi);
  endfunction

  function automatic bit in_window(input logic [31:0] b, input logic [7:0] x,
                                   input logic [7:0] y);
    return in_span(y, b[31:24], b[23:16]) && in_span(x, b[15:8], b[7:0]);
  endfunction

  function automatic rgb_t composite_pixel(input pixel_t p, input cfg_t c);
    logic [3:0] bg_on;
    logic [5:0] allow;
    logic [7:0] key, key1, key2;
    rgb_t       col, col1, col2, res;
    logic [2:0] lay1, lay2;
    blend_op_t  op;
    bit         take, first, forced;
    int         wa, wb, wy, v;
    bg_on = c.display[11:8];
    if (c.display[2:0] == MODE_NO_BG3) bg_on &= 4'b0111;
    else if (c.display[2:0] == MODE_NO_BG01) bg_on &= 4'b1100;
    else if (c.display[2:0] >= MODE_BG2_LO && c.display[2:0] <= MODE_BG2_HI)
      bg_on &= 4'b0100;

    // window 0 over window 1 over object window over outside
    allow = 6'h3F;
    if (|c.display[15:13]) begin
      allow = c.masks[21:16];
      if (c.display[15] && p.obj_opaque) allow = c.masks[29:24];
      if (c.display[14] && in_window(c.win1, p.x, p.line)) allow = c.masks[13:8];
      if (c.display[13] && in_window(c.win0, p.x, p.line)) allow = c.masks[5:0];
    end

    key1 = 8'hFF;
    key2 = 8'hFF;
    col1 = c.backdrop;
    col2 = c.backdrop;
    lay1 = LAYER_BACKDROP;
    lay2 = LAYER_BACKDROP;
    for (int i = 0; i < 5; i++) begin
      if (i < 4) begin
        take = bg_on[i] && allow[i] && p.bg_opaque[i];
        key = 8'(int'(p.bg_priorities[2*i +: 2]) * 8 + i + 1);
        col = p.bg_color[i];
      end else begin
        take = c.display[12] && p.obj_opaque && allow[4];
        key = 8'(int'(p.obj_priority) * 8);
        col = p.obj_color;
      end
      if (take) begin
        if (key < key1) begin
          key2 = key1;
          col2 = col1;
          lay2 = lay1;
          key1 = key;
          col1 = col;
          lay1 = 3'(i);
        end else if (key < key2) begin
          key2 = key;
          col2 = col;
          lay2 = 3'(i);
        end
      end
    end

    res = col1;
    if (allow[5]) begin
      op = blend_op_t'(c.blend[7:6]);
      first = c.blend[lay1];
      forced = (lay1 == LAYER_OBJ) && p.obj_semi;
      if (forced || (op == OP_ALPHA && first)) begin
        if (c.blend[8 + int'(lay2)]) begin
          wa = int'(c.alpha[4:0]);
          wb = int'(c.alpha[12:8]);
          if (wa > int'(WEIGHT_MAX)) wa = int'(WEIGHT_MAX);
          if (wb > int'(WEIGHT_MAX)) wb = int'(WEIGHT_MAX);
          for (int ch = 0; ch < 3; ch++) begin
            v = (int'(col1[5*ch +: 5]) * wa + int'(col2[5*ch +: 5]) * wb)
                / int'(WEIGHT_MAX);
            if (v > int'(CHAN_MAX)) v = int'(CHAN_MAX);
            res[5*ch +: 5] = 5'(v);
          end
        end
      end else if ((op == OP_BRIGHT || op == OP_DARK) && first) begin
        wy = int'(c.bright);
        if (wy > int'(WEIGHT_MAX)) wy = int'(WEIGHT_MAX);
        for (int ch = 0; ch < 3; ch++) begin
          v = int'(col1[5*ch +: 5]);
          if (op == OP_BRIGHT) v = v + (int'(CHAN_MAX) - v) * wy / int'(WEIGHT_MAX);
          else v = v - v * wy / int'(WEIGHT_MAX);
          res[5*ch +: 5] = 5'(v);
        end
      end
    end
    return res;
  endfunction

  function automatic pixel_t pix_of(input logic [7:0] x, input logic [7:0] line,
                                    input rgb_t c0, input rgb_t c1, input rgb_t c2,
                                    input rgb_t c3, input logic [3:0] opq,
                                    input logic [7:0] prio, input rgb_t oc,
                                    input logic oo, input logic [1:0] op, input logic os);
    pixel_t p;
    p.x = x;
    p.line = line;
    p.bg_color[0] = c0;
    p.bg_color[1] = c1;
    p.bg_color[2] = c2;
    p.bg_color[3] = c3;
    p.bg_opaque = opq;
    p.bg_priorities = prio;
    p.obj_color = oc;
    p.obj_opaque = oo;
    p.obj_priority = op;
    p.obj_semi = os;
    return p;
  endfunction

  task automatic note_error(input string what);
    errors++;
    if (errors <= 10) $display("%s", what);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_DISPLAY:  regs_now.display  = val[15:0];
      CFG_BLEND:    regs_now.blend    = val[13:0];
      CFG_ALPHA:    regs_now.alpha    = val[15:0];
      CFG_BRIGHT:   regs_now.bright   = val[4:0];
      CFG_WIN0:     regs_now.win0     = val;
      CFG_WIN1:     regs_now.win1     = val;
      CFG_MASKS:    regs_now.masks    = val;
      CFG_BACKDROP: regs_now.backdrop = val[14:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input cfg_t c);
    write_reg(CFG_DISPLAY,  32'(c.display));
    write_reg(CFG_BLEND,    32'(c.blend));
    write_reg(CFG_ALPHA,    32'(c.alpha));
    write_reg(CFG_BRIGHT,   32'(c.bright));
    write_reg(CFG_WIN0,     c.win0);
    write_reg(CFG_WIN1,     c.win1);
    write_reg(CFG_MASKS,    c.masks);
    write_reg(CFG_BACKDROP, 32'(c.backdrop));
    cfg_valid <= 1'b0;
  endtask

  // stop the pixel stream and wait until every pixel in flight is out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_pixel(input pixel_t p, input bit known, input rgb_t color);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, p.obj_semi, p.obj_priority, p.obj_opaque, p.obj_color,
                      p.bg_priorities, p.bg_opaque, p.bg_color[3], p.bg_color[2],
                      p.bg_color[1], p.bg_color[0], p.line, p.x};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    colors_due.push_back(known ? color : composite_pixel(p, regs_now));
  endtask

  // output side: random back-pressure unless steady, and compare against the oldest prediction
  initial begin
    int   stall;
    rgb_t due;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      if (colors_due.size() == 0) begin
        note_error($sformatf("unexpected output transfer: pixel_color %h",
                             m_axis_tdata[14:0]));
      end else begin
        due = colors_due.pop_front();
        if (m_axis_tdata[14:0] !== due)
          note_error($sformatf("pixel_color mismatch: expected %h, got %h",
                               due, m_axis_tdata[14:0]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b1 || (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("layer_window_blend_compositor regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int     cur;
    cfg_t   c;
    pixel_t p;
    errors = 0;
    idle_cycles = 0;
    steady = 1'b0;
    regs_now = '0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DISPLAY;
    cfg_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;

    setups[0] = '0;
    setups[1] = '{display: 16'h1F00, backdrop: 15'h7FFF, default: '0};
    setups[2] = '{display: 16'h1F03, backdrop: 15'h0421, default: '0};
    setups[3] = '{display: 16'h1F00, blend: 14'h3F7F, alpha: 16'h1F1F, default: '0};
    setups[4] = '{display: 16'h1F00, blend: 14'h00BF, bright: 5'd31, default: '0};
    setups[5] = '{display: 16'h1F00, blend: 14'h00FF, bright: 5'd31, default: '0};
    setups[6] = '{display: 16'hFF01, blend: 14'h3F42, alpha: 16'h0A06,
                  win0: 32'h960AC828, win1: 32'h32321414, masks: 32'h2102013F,
                  bright: 5'd0, backdrop: 15'h5294};
    setups[7] = '{display: 16'h1F00, blend: 14'h0100, alpha: 16'h0808, default: '0};

    // registers at reset: nothing shown, black backdrop
    directed.push_back('{0, pix_of(8'd239, 8'd159, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
                       4'hF, 8'hFF, 15'h7FFF, 1'b1, 2'd3, 1'b1), 1'b1, 15'h0000});
    directed.push_back('{0, pix_of(8'd0, 8'd0, 15'h0, 15'h0, 15'h0, 15'h0,
                       4'h0, 8'h00, 15'h0, 1'b0, 2'd0, 1'b0), 1'b1, 15'h0000});
    // priority ordering
    directed.push_back('{1, pix_of(8'd12, 8'd34, 15'h1111, 15'h2222, 15'h3333, 15'h4444,
                       4'h0, 8'h00, 15'h5555, 1'b0, 2'd0, 1'b0), 1'b1, 15'h7FFF});
    directed.push_back('{1, pix_of(8'd0, 8'd0, 15'h1234, 15'h2222, 15'h3333, 15'h4444,
                       4'h1, 8'hFF, 15'h5555, 1'b0, 2'd0, 1'b0), 1'b1, 15'h1234});
    directed.push_back('{1, pix_of(8'd120, 8'd80, 15'h1111, 15'h2222, 15'h3333, 15'h4444,
                       4'hF, 8'h00, 15'h5555, 1'b0, 2'd0, 1'b0), 1'b1, 15'h1111});
    directed.push_back('{1, pix_of(8'd120, 8'd80, 15'h1111, 15'h2222, 15'h3333, 15'h4444,
                       4'hF, 8'h00, 15'h5555, 1'b1, 2'd0, 1'b0), 1'b1, 15'h5555});
    directed.push_back('{1, pix_of(8'd120, 8'd80, 15'h1111, 15'h2222, 15'h3333, 15'h4444,
                       4'hF, 8'h3F, 15'h5555, 1'b0, 2'd0, 1'b0), 1'b1, 15'h4444});
    directed.push_back('{1, pix_of(8'd120, 8'd80, 15'h1111, 15'h2222, 15'h3333, 15'h4444,
                       4'hF, 8'hFF, 15'h5555, 1'b1, 2'd3, 1'b0), 1'b1, 15'h5555});
    // bitmap mode keeps only bg2
    directed.push_back('{2, pix_of(8'd5, 8'd6, 15'h1111, 15'h2222, 15'h3333, 15'h4444,
                       4'hF, 8'h00, 15'h5555, 1'b0, 2'd0, 1'b0), 1'b0, 15'h0});
    directed.push_back('{2, pix_of(8'd5, 8'd6, 15'h1111, 15'h2222, 15'h3333, 15'h4444,
                       4'hF, 8'hFF, 15'h5555, 1'b1, 2'd2, 1'b0), 1'b0, 15'h0});
    directed.push_back('{2, pix_of(8'd5, 8'd6, 15'h1111, 15'h2222, 15'h3333, 15'h4444,
                       4'h3, 8'h00, 15'h5555, 1'b0, 2'd0, 1'b0), 1'b1, 15'h0421});
    // alpha saturation
    directed.push_back('{3, pix_of(8'd0, 8'd0, 15'h7FFF, 15'h7FFF, 15'h0, 15'h0,
                       4'h3, 8'hE4, 15'h0, 1'b0, 2'd0, 1'b0), 1'b1, 15'h7FFF});
    directed.push_back('{3, pix_of(8'd0, 8'd0, 15'h0, 15'h0, 15'h0, 15'h0,
                       4'h3, 8'hE4, 15'h0, 1'b0, 2'd0, 1'b0), 1'b1, 15'h0000});
    directed.push_back('{3, pix_of(8'd77, 8'd33, 15'h4210, 15'h1CE7, 15'h0, 15'h0,
                       4'h3, 8'hE4, 15'h0, 1'b0, 2'd0, 1'b0), 1'b0, 15'h0});
    // full brighten and full darken
    directed.push_back('{4, pix_of(8'd0, 8'd0, 15'h1234, 15'h0, 15'h0, 15'h0,
                       4'h1, 8'h00, 15'h0, 1'b0, 2'd0, 1'b0), 1'b1, 15'h7FFF});
    directed.push_back('{4, pix_of(8'd0, 8'd0, 15'h1234, 15'h0, 15'h0, 15'h0,
                       4'h0, 8'h00, 15'h0, 1'b0, 2'd0, 1'b0), 1'b1, 15'h7FFF});
    directed.push_back('{5, pix_of(8'd0, 8'd0, 15'h7FFF, 15'h0, 15'h0, 15'h0,
                       4'h1, 8'h00, 15'h0, 1'b0, 2'd0, 1'b0), 1'b1, 15'h0000});
    // wrapping window 0, empty window 1, object window, outside
    directed.push_back('{6, pix_of(8'd0, 8'd0, 15'h1111, 15'h2A4C, 15'h3333, 15'h4444,
                       4'hF, 8'hE4, 15'h6318, 1'b0, 2'd0, 1'b0), 1'b0, 15'h0});
    directed.push_back('{6, pix_of(8'd239, 8'd159, 15'h1111, 15'h2A4C, 15'h3333, 15'h4444,
                       4'hF, 8'hE4, 15'h6318, 1'b1, 2'd0, 1'b0), 1'b0, 15'h0});
    directed.push_back('{6, pix_of(8'd100, 8'd80, 15'h1111, 15'h2A4C, 15'h3333, 15'h4444,
                       4'hF, 8'hE4, 15'h6318, 1'b1, 2'd0, 1'b1), 1'b0, 15'h0});
    directed.push_back('{6, pix_of(8'd100, 8'd80, 15'h1111, 15'h2A4C, 15'h3333, 15'h4444,
                       4'hF, 8'hE4, 15'h6318, 1'b0, 2'd0, 1'b0), 1'b0, 15'h0});
    directed.push_back('{6, pix_of(8'd255, 8'd255, 15'h1111, 15'h2A4C, 15'h3333, 15'h4444,
                       4'hF, 8'hE4, 15'h6318, 1'b1, 2'd1, 1'b0), 1'b0, 15'h0});
    directed.push_back('{6, pix_of(8'd40, 8'd10, 15'h1111, 15'h2A4C, 15'h3333, 15'h4444,
                       4'hF, 8'hE4, 15'h6318, 1'b0, 2'd0, 1'b0), 1'b0, 15'h0});
    // semi-transparent sprite: forced blend, no second target, not on top
    directed.push_back('{7, pix_of(8'd0, 8'd0, 15'h03FF, 15'h0, 15'h0, 15'h0,
                       4'h1, 8'hFF, 15'h7C00, 1'b1, 2'd0, 1'b1), 1'b0, 15'h0});
    directed.push_back('{7, pix_of(8'd0, 8'd0, 15'h03FF, 15'h0, 15'h0, 15'h0,
                       4'h0, 8'h00, 15'h7C00, 1'b1, 2'd0, 1'b1), 1'b1, 15'h7C00});
    directed.push_back('{7, pix_of(8'd0, 8'd0, 15'h03FF, 15'h0, 15'h0, 15'h0,
                       4'h1, 8'h00, 15'h7C00, 1'b1, 2'd1, 1'b1), 1'b0, 15'h0});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    cur = -1;
    foreach (directed[k]) begin
      if (directed[k].setup != cur) begin
        cur = directed[k].setup;
        drain();
        load_regs(setups[cur]);
      end
      send_pixel(directed[k].pix, directed[k].known, directed[k].color);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        c = '1;
      end else if (ph == 1) begin
        c = '0;
      end else begin
        c.display  = 16'($urandom);
        c.blend    = 14'($urandom);
        c.alpha    = 16'($urandom);
        c.bright   = 5'($urandom);
        c.win0     = {8'($urandom_range(0, 160)), 8'($urandom_range(0, 160)),
                      8'($urandom_range(0, 240)), 8'($urandom_range(0, 240))};
        c.win1     = {8'($urandom_range(0, 160)), 8'($urandom_range(0, 160)),
                      8'($urandom_range(0, 240)), 8'($urandom_range(0, 240))};
        c.masks    = $urandom;
        c.backdrop = 15'($urandom);
      end
      drain();
      steady = ($urandom_range(0, 3) == 0);
      load_regs(c);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        p.x = 8'($urandom_range(0, 239));
        p.line = 8'($urandom_range(0, 159));
        for (int b = 0; b < 4; b++) p.bg_color[b] = 15'($urandom);
        p.bg_opaque = 4'($urandom);
        p.bg_priorities = 8'($urandom);
        p.obj_color = 15'($urandom);
        p.obj_opaque = 1'($urandom);
        p.obj_priority = 2'($urandom);
        p.obj_semi = 1'($urandom);
        send_pixel(p, 1'b0, 15'h0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("layer_window_blend_compositor regression: pass");
    end else begin
      $display("layer_window_blend_compositor regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/lwbc_pkg.sv
sv/lwbc_window.sv
sv/lwbc_rank.sv
sv/lwbc_blend.sv
sv/layer_window_blend_compositor.sv
bench/layer_window_blend_compositor_tb.sv
